// File: rtl/sht_pkg.sv
package sht_pkg;

  localparam int ID_W   = 32;
  localparam int CNT_W  = 32;
  localparam int FB_W   = 2;
  localparam int WORD_W = ID_W + FB_W;

  // feedback codes
  localparam logic [FB_W-1:0] FB_TIE     = 2'd0;
  localparam logic [FB_W-1:0] FB_LIKE    = 2'd1;
  localparam logic [FB_W-1:0] FB_DISLIKE = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_APPENDED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // request kinds
  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  function automatic logic [FB_W-1:0] judge(input logic [CNT_W-1:0] likes,
                                            input logic [CNT_W-1:0] dislikes);
    logic [FB_W-1:0] fb;
    if (likes == dislikes) begin
      fb = FB_TIE;
    end else if (likes > dislikes) begin
      fb = FB_LIKE;
    end else begin
      fb = FB_DISLIKE;
    end
    return fb;
  endfunction

endpackage

// File: rtl/sht_ram.sv
module sht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sorted_history_table.sv
// Channel  Dir  Signals                          Contents
// s_*      in   s_tvalid s_tready s_tdata s_tuser request item: func, stream_id, likes, dislikes
// m_*      out  m_tvalid m_tready m_tdata m_tuser result item: status, entry_count, feedback
//
// Append: write and count at the accepting edge; the result then passes through DONE.
// Remove: each bisection step passes SEARCH and CMP; a hit goes to SHIFT, which moves every entry
//   above the hit one place lower and closes the gap; worst is a hit at index 0 in a full table.
// Reset (rst, synchronous) clears the count and the control state; the RAM keeps
//   its contents, only entries below the count are ever read.
// A finished item waits in the output register while the next request is taken; a
//   second result waits in DONE with s_tready low until the register frees.
module sorted_history_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // stream_id[31:0], likes[63:32], dislikes[95:64]
  input  logic [0:0]  s_tuser,   // func[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // entry_count[8:0], feedback[10:9], zero[15:11]
  output logic [1:0]  m_tuser    // status[1:0]
);

  import sht_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    IDLE,
    SEARCH,
    CMP,
    SHIFT,
    DONE
  } state_t;

  state_t           state;
  logic [CW-1:0]    count;
  logic [ID_W-1:0]  key_id;
  logic [CW-1:0]    left;
  logic [CW-1:0]    hi;        // exclusive upper bound of the search window
  logic [IW-1:0]    mid;
  logic [CW-1:0]    rd_ptr;
  logic             wr_pend;
  logic [IW-1:0]    wr_addr;
  status_t          res_status;
  logic [FB_W-1:0]  res_fb;

  logic             s_acc;
  logic             s_func;
  logic [ID_W-1:0]  s_id;
  logic [CNT_W-1:0] s_likes;
  logic [CNT_W-1:0] s_dislikes;
  logic [CW:0]      mid_sum;
  logic [IW-1:0]    mid_next;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [ID_W-1:0]   here_id;
  logic [FB_W-1:0]   here_fb;
  logic [CW-1:0]     mid_ext;

  assign s_tready   = (state == IDLE);
  assign s_acc      = s_tvalid && s_tready;
  assign s_func     = s_tuser[0];
  assign s_id       = s_tdata[31:0];
  assign s_likes    = s_tdata[63:32];
  assign s_dislikes = s_tdata[95:64];

  // midpoint of [left, hi-1], hi is at least one inside the search
  assign mid_sum  = (CW+1)'(left) + (CW+1)'(hi) - (CW+1)'(1);
  assign mid_next = mid_sum[IW:1];
  assign mid_ext  = CW'(mid);

  assign here_id = ram_rdata[WORD_W-1:FB_W];
  assign here_fb = ram_rdata[FB_W-1:0];

  // RAM port steering: append writes at the end, the gap close writes the
  // registered RAM read data back one place lower
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = ram_rdata;
    ram_raddr = mid_next;
    case (state)
      IDLE: begin
        ram_we    = s_acc && (s_func == FUNC_APPEND) && (count < CW'(TABLE_DEPTH));
        ram_waddr = count[IW-1:0];
        ram_wdata = {s_id, judge(s_likes, s_dislikes)};
      end
      SHIFT: begin
        ram_we    = wr_pend;
        ram_raddr = rd_ptr[IW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      wr_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the result once taken, unless DONE loads the next one
      if (m_tvalid && m_tready && (state != DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_acc) begin
            key_id <= s_id;
            left   <= '0;
            hi     <= count;
            if (s_func == FUNC_APPEND) begin
              state <= DONE;
              if (count < CW'(TABLE_DEPTH)) begin
                count      <= count + CW'(1);
                res_fb     <= judge(s_likes, s_dislikes);
                res_status <= ST_APPENDED;
              end else begin
                res_fb     <= FB_TIE;
                res_status <= ST_FULL;
              end
            end else begin
              res_fb     <= FB_TIE;
              res_status <= ST_NOT_FOUND;
              if (count != '0) begin
                state <= SEARCH;
              end else begin
                state <= DONE;
              end
            end
          end
        end
        SEARCH: begin
          // read of the midpoint is issued this cycle
          mid   <= mid_next;
          state <= CMP;
        end
        CMP: begin
          if (here_id < key_id) begin
            left <= mid_ext + CW'(1);
            if ((mid_ext + CW'(1)) < hi) begin
              state <= SEARCH;
            end else begin
              state <= DONE;
            end
          end else if (key_id < here_id) begin
            hi <= mid_ext;
            if (left < mid_ext) begin
              state <= SEARCH;
            end else begin
              state <= DONE;
            end
          end else begin
            res_fb     <= here_fb;
            res_status <= ST_REMOVED;
            rd_ptr     <= mid_ext + CW'(1);
            wr_pend    <= 1'b0;
            state      <= SHIFT;
          end
        end
        SHIFT: begin
          if (rd_ptr < count) begin
            rd_ptr  <= rd_ptr + CW'(1);
            wr_pend <= 1'b1;
            wr_addr <= IW'(rd_ptr - CW'(1));
          end else begin
            // last pending write lands this cycle
            wr_pend <= 1'b0;
            count   <= count - CW'(1);
            state   <= DONE;
          end
        end
        DONE: begin
          // hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {5'b0, res_fb, 9'(count)};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    (state == SEARCH) |-> (left < hi) && (hi <= count))
    else $error("bisection window empty or beyond the count");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (state == SHIFT && wr_pend) |-> (CW'(wr_addr) + CW'(1) < count))
    else $error("gap close writes outside the held entries");

  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == IDLE) |-> (s_acc && s_func == FUNC_APPEND))
    else $error("table written without an append");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE && !s_acc) |=> $stable(count))
    else $error("count changed with no item in work");
`endif

endmodule

// File: tb/tb_sorted_history_table.sv
`timescale 1ns / 1ps

module tb_sorted_history_table;
  import sht_pkg::*;

  localparam int DEPTH        = 256;
  localparam int RAND_ITEMS   = 1530;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic        func;
    logic [31:0] id;
    logic [31:0] likes;
    logic [31:0] dislikes;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [8:0]  count;
    logic [1:0]  fb;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // stream_id[31:0], likes[63:32], dislikes[95:64]
  logic [0:0]  s_tuser = '0;   // func[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // entry_count[8:0], feedback[10:9]
  logic [1:0]  m_tuser;        // status[1:0]

  always #10 clk = ~clk;

  sorted_history_table #(.TABLE_DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the history table, advanced once per accepted request
  logic [31:0] shadow_ids [DEPTH];
  logic [1:0]  shadow_fb  [DEPTH];
  int          shadow_fill = 0;

  request_t    request_q [$];
  outcome_t    predicted_q [$];
  request_t    in_flight;
  int          mismatch_count = 0;

  // Stimulus-side view of the ids held, used to aim removals at live ids and to steer appends and fills
  logic [31:0] live_ids [$];
  logic [31:0] last_id = '0;
  int          id_stride = 1000;

  bit          req_taken = 1'b0;
  bit          res_taken = 1'b0;
  int          src_gap = 0;
  int          snk_stall = 0;
  bit          src_calm = 1'b0;
  bit          snk_calm = 1'b0;

  // Apply one request to the shadow table and return the result it must give
  function automatic outcome_t apply_history_op(request_t r);
    outcome_t o;
    int lo, hi, mid;
    bit hit;
    o.fb = FB_TIE;
    hit = 1'b0;
    if (r.func == FUNC_APPEND) begin
      if (shadow_fill >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        if (r.likes == r.dislikes) begin
          o.fb = FB_TIE;
        end else if (r.likes > r.dislikes) begin
          o.fb = FB_LIKE;
        end else begin
          o.fb = FB_DISLIKE;
        end
        shadow_ids[shadow_fill] = r.id;
        shadow_fb[shadow_fill]  = o.fb;
        shadow_fill++;
        o.status = ST_APPENDED;
      end
    end else begin
      // bisect; lo passing hi (hi going negative included) ends the search as not found
      o.status = ST_NOT_FOUND;
      lo = 0;
      hi = shadow_fill - 1;
      while (lo <= hi && !hit) begin
        mid = (lo + hi) / 2;
        if (shadow_ids[mid] < r.id) begin
          lo = mid + 1;
        end else if (r.id < shadow_ids[mid]) begin
          hi = mid - 1;
        end else begin
          hit = 1'b1;
          o.fb = shadow_fb[mid];
          // close the gap left by the deleted entry
          for (int k = mid; k < shadow_fill - 1; k++) begin
            shadow_ids[k] = shadow_ids[k + 1];
            shadow_fb[k]  = shadow_fb[k + 1];
          end
          shadow_fill--;
          o.status = ST_REMOVED;
        end
      end
    end
    o.count = 9'(shadow_fill);
    return o;
  endfunction

  task automatic queue_append(input logic [31:0] id, input logic [31:0] likes,
                              input logic [31:0] dislikes);
    request_t r;
    r.func     = FUNC_APPEND;
    r.id       = id;
    r.likes    = likes;
    r.dislikes = dislikes;
    request_q.push_back(r);
    if (live_ids.size() < DEPTH) live_ids.push_back(id);
    last_id = id;
  endtask

  task automatic queue_remove(input logic [31:0] id);
    request_t r;
    int k;
    r.func     = FUNC_REMOVE;
    r.id       = id;
    r.likes    = $urandom;
    r.dislikes = $urandom;
    request_q.push_back(r);
    for (k = 0; k < live_ids.size(); k++) begin
      if (live_ids[k] == id) break;
    end
    if (k < live_ids.size()) live_ids.delete(k);
  endtask

  // Mostly ascending ids; a few out of order or repeated
  task automatic queue_random_append();
    logic [31:0] id, lk, dk;
    int pick;
    pick = $urandom_range(0, 99);
    if (live_ids.size() == 0 || pick < 5) begin
      id = $urandom;
    end else if (pick < 10) begin
      id = last_id;
    end else begin
      id = last_id + $urandom_range(1, id_stride);
    end
    case ($urandom_range(0, 3))
      0: begin
        lk = $urandom;
        dk = lk;
      end
      1: begin
        lk = $urandom_range(0, 3);
        dk = $urandom_range(0, 3);
      end
      default: begin
        lk = $urandom;
        dk = $urandom;
      end
    endcase
    queue_append(id, lk, dk);
  endtask

  // Mostly live ids, the head entry often, plus near misses and noise
  task automatic queue_random_remove();
    logic [31:0] id;
    int pick, k;
    pick = $urandom_range(0, 99);
    if (live_ids.size() == 0 || pick < 15) begin
      id = $urandom;
    end else begin
      k  = (pick < 30) ? 0 : $urandom_range(0, live_ids.size() - 1);
      id = live_ids[k];
      if (pick >= 85) id = pick[0] ? id + 1 : id - 1;
    end
    queue_remove(id);
  endtask

  // Stimulus, then wait for the drain and give the verdict
  initial begin
    int pick, len, full_runs, target;
    full_runs = 0;

    // Directed part
    queue_remove(32'h0000_0000);                                 // empty table
    queue_append(32'd10, 32'hFFFF_FFFF, 32'h0000_0000);          // like, extreme counts
    queue_append(32'd20, 32'h0000_0000, 32'hFFFF_FFFF);          // dislike
    queue_remove(32'd3);                                         // steps left of index zero
    queue_remove(32'd15);                                        // miss between entries
    queue_remove(32'hFFFF_FFFF);                                 // miss past the end
    queue_append(32'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF);          // duplicate id, tie
    queue_append(32'd30, 32'd5, 32'd6);
    queue_append(32'hFFFF_FFFF, 32'd7, 32'd6);
    queue_remove(32'd20);                                        // duplicate: first hit goes
    queue_remove(32'd10);                                        // head entry, longest shift
    queue_remove(32'hFFFF_FFFF);                                 // tail entry, no shift
    queue_append(32'd5, 32'd0, 32'd0);                           // out of order
    queue_remove(32'd5);                                         // bisection misses it
    queue_remove(32'd30);
    queue_remove(32'd20);
    queue_remove(32'd5);
    queue_append(32'h0000_0000, 32'd0, 32'd0);
    queue_append(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    queue_append(32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_remove(32'h0000_0000);
    queue_remove(32'hFFFF_FFFF);
    queue_remove(32'hAAAA_AAAA);

    // Random part in phases: grow, shrink, mix, and now and then fill to the brim
    target = request_q.size() + RAND_ITEMS;
    while (request_q.size() < target) begin
      pick      = $urandom_range(0, 99);
      len       = $urandom_range(1, 30);
      id_stride = ($urandom_range(0, 7) == 0) ? (1 << 20) : 1000;
      if (pick < 8 && full_runs < 3) begin
        full_runs++;
        while (live_ids.size() < DEPTH) queue_random_append();
        repeat ($urandom_range(1, 5)) queue_random_append();   // dropped as full
        queue_remove(live_ids[0]);
        repeat (len) queue_random_remove();
      end else if (pick < 45) begin
        repeat (len) queue_random_append();
      end else if (pick < 85) begin
        repeat (len) queue_random_remove();
      end else begin
        repeat (len) begin
          if ($urandom_range(0, 1)) queue_random_append();
          else queue_random_remove();
        end
      end
    end

    while (request_q.size() > 0 || s_tvalid) @(posedge clk);
    while (predicted_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hold reset, then release it on a falling edge
  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(50_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Sample both handshakes; predict on request, check on result
  always @(posedge clk) begin : observe
    outcome_t want;
    req_taken = !rst && s_tvalid && s_tready;
    res_taken = !rst && m_tvalid && m_tready;
    if (req_taken) predicted_q.push_back(apply_history_op(in_flight));
    if (res_taken) begin
      if (predicted_q.size() == 0) begin
        note_mismatch("unexpected result, status", -1, m_tuser);
      end else begin
        want = predicted_q.pop_front();
        if (m_tuser !== want.status)      note_mismatch("status", want.status, m_tuser);
        if (m_tdata[8:0] !== want.count)  note_mismatch("entry_count", want.count, m_tdata[8:0]);
        if (m_tdata[10:9] !== want.fb)    note_mismatch("feedback", want.fb, m_tdata[10:9]);
      end
    end
  end

  // Request driver: hold the item until taken, then wait the drawn gap
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || req_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_flight = request_q.pop_front();
        s_tuser  <= in_flight.func;
        s_tdata  <= {in_flight.dislikes, in_flight.likes, in_flight.id};
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
        src_gap = src_calm ? 0 : $urandom_range(0, 13);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: after each result, stall for a drawn number of cycles
  always @(negedge clk) begin
    if (res_taken) begin
      if ($urandom_range(0, 49) == 0) snk_calm = !snk_calm;
      snk_stall = snk_calm ? 0 : $urandom_range(0, 13);
    end
    if (snk_stall > 0) begin
      snk_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

endmodule

// File: files.f
rtl/sht_pkg.sv
rtl/sht_ram.sv
rtl/sorted_history_table.sv
tb/tb_sorted_history_table.sv
